// ===== rtl/rse_pkg.sv =====
// Shared types, codes and sizes for the record stack engine.
// No dependencies; every other file imports this package.
package rse_pkg;

  localparam int DEPTH      = 32;
  localparam int NAME_BYTES = 14;

  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int HALF_W  = 56;
  localparam int AGE_W   = 7;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ENTRY_W = 6;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP  = 3'd1;
  localparam logic [2:0] OP_ALL  = 3'd2;
  localparam logic [2:0] OP_LIST = 3'd3;

  localparam logic [1:0] FC_NAME = 2'd0;
  localparam logic [1:0] FC_AGE  = 2'd1;

  function automatic logic [HALF_W-1:0] name_mask(input int bytes);
    logic [HALF_W-1:0] m;
    m = '0;
    for (int i = 0; i < HALF_W / 8; i++) begin
      if (i < bytes) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

  localparam logic [HALF_W-1:0] MASK_FIRST  = name_mask(NAME_BYTES);
  localparam logic [HALF_W-1:0] MASK_SECOND = name_mask(NAME_BYTES - 7);

  typedef enum logic [2:0] {
    K_PUSH,
    K_POP,
    K_ALL,
    K_LIST,
    K_COUNT
  } kind_t;

  typedef enum logic [2:0] {
    C_NAME,
    C_AGE,
    C_DATE,
    C_RECORD,
    C_COUNT
  } content_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_FULL
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic [HALF_W-1:0]  name_first;
    logic [HALF_W-1:0]  name_second;
    logic [AGE_W-1:0]   age;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } rec_t;

  typedef struct packed {
    kind_t    kind;
    content_t choice;
    rec_t     rec;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    content_t            content;
    rec_t                rec;
    logic [ENTRY_W-1:0]  entries;
    logic                last;
  } res_t;

endpackage

// ===== rtl/record_stack_engine_core.sv =====
// Top level of the record stack engine: front end, command queue, back end.
// Depends on rse_pkg, rse_front, rse_cmd_fifo and rse_back.
//
// A LIFO of up to 32 person records behind queue-style ports on both sides.
// Push of a record, count, and any command that answers at once (empty stack,
// full stack) skips the read state, so a steady stream of them runs at one
// beat per cycle while the result side does not stall. Pop of one field goes
// through the read state since the record memory has a registered read port;
// pop-all and list stay there until each stored record, top first, is sent.
// A two-entry command queue lets the input keep accepting beats while the back
// end works or the result side stalls; memory needs no clearing after reset.
module record_stack_engine_core
  import rse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         opcode,
  input  logic [1:0]         field_choice,
  input  logic [HALF_W-1:0]  name_first,
  input  logic [HALF_W-1:0]  name_second,
  input  logic [AGE_W-1:0]   age_in,
  input  logic [YEAR_W-1:0]  year_in,
  input  logic [MONTH_W-1:0] month_in,
  input  logic [DAY_W-1:0]   day_in,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic [2:0]         content,
  output logic [HALF_W-1:0]  name_first_out,
  output logic [HALF_W-1:0]  name_second_out,
  output logic [AGE_W-1:0]   age_out,
  output logic [YEAR_W-1:0]  year_out,
  output logic [MONTH_W-1:0] month_out,
  output logic [DAY_W-1:0]   day_out,
  output logic [ENTRY_W-1:0] entries,
  output logic               last
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_we;
  logic queue_valid;
  logic queue_take;
  res_t res;

  rse_front u_front (
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .field_choice (field_choice),
    .name_first   (name_first),
    .name_second  (name_second),
    .age_in       (age_in),
    .year_in      (year_in),
    .month_in     (month_in),
    .day_in       (day_in),
    .cmd_we       (front_we),
    .cmd          (front_cmd)
  );

  rse_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_we),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (queue_take),
    .rd_data (queue_cmd),
    .valid   (queue_valid)
  );

  rse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd       (queue_cmd),
    .cmd_take  (queue_take),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign status          = res.status;
  assign content         = res.content;
  assign name_first_out  = res.rec.name_first;
  assign name_second_out = res.rec.name_second;
  assign age_out         = res.rec.age;
  assign year_out        = res.rec.year;
  assign month_out       = res.rec.month;
  assign day_out         = res.rec.day;
  assign entries         = res.entries;
  assign last            = res.last;

endmodule

// ===== rtl/rse_front.sv =====
// Front end: takes input beats and decodes them into stack commands.
// Depends on rse_pkg.
module rse_front
  import rse_pkg::*;
(
  input  logic               push,
  input  logic               full,
  input  logic [2:0]         opcode,
  input  logic [1:0]         field_choice,
  input  logic [HALF_W-1:0]  name_first,
  input  logic [HALF_W-1:0]  name_second,
  input  logic [AGE_W-1:0]   age_in,
  input  logic [YEAR_W-1:0]  year_in,
  input  logic [MONTH_W-1:0] month_in,
  input  logic [DAY_W-1:0]   day_in,
  output logic               cmd_we,
  output cmd_t               cmd
);

  assign cmd_we = push && !full;

  always_comb begin
    case (opcode)
      OP_PUSH: cmd.kind = K_PUSH;
      OP_POP:  cmd.kind = K_POP;
      OP_ALL:  cmd.kind = K_ALL;
      OP_LIST: cmd.kind = K_LIST;
      default: cmd.kind = K_COUNT;
    endcase
    case (field_choice)
      FC_NAME: cmd.choice = C_NAME;
      FC_AGE:  cmd.choice = C_AGE;
      default: cmd.choice = C_DATE;
    endcase
    cmd.rec.name_first  = name_first & MASK_FIRST;
    cmd.rec.name_second = name_second & MASK_SECOND;
    cmd.rec.age         = age_in;
    cmd.rec.year        = year_in;
    cmd.rec.month       = month_in;
    cmd.rec.day         = day_in;
  end

endmodule

// ===== rtl/rse_cmd_fifo.sv =====
// Short command queue between the front end and the stack back end.
// Depends on rse_pkg.
module rse_cmd_fifo
  import rse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic valid
);

  cmd_t               slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] count;

  assign full    = (count == CMDQ_CW'(CMDQ_DEPTH));
  assign valid   = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_data;
  end

endmodule

// ===== rtl/rse_back.sv =====
// Back end: record memory, fill level, read sequencer and result register.
// Depends on rse_pkg.
module rse_back
  import rse_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  input  logic pop,
  output logic empty,
  output res_t res
);

  rec_t mem [DEPTH];
  rec_t rd_data;

  state_t             state, state_next;
  logic [FILL_W-1:0]  fill, fill_next;
  logic [PTR_W-1:0]   ptr, ptr_next;
  kind_t              cur_kind, kind_next;
  content_t           cur_choice, choice_next;
  logic               out_valid;
  logic               out_room;
  logic               out_load;
  res_t               res_next;
  logic               mem_we;
  logic               rd_en;
  logic [PTR_W-1:0]   rd_addr;

  assign empty    = !out_valid;
  assign out_room = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    cur_kind   <= kind_next;
    cur_choice <= choice_next;
    if (out_load) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[PTR_W'(fill)] <= cmd.rec;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    ptr_next    = ptr;
    kind_next   = cur_kind;
    choice_next = cur_choice;
    cmd_take    = 1'b0;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = ptr;
    out_load    = 1'b0;
    res_next    = '0;
    res_next.last = 1'b1;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            K_PUSH: begin
              if (fill == FILL_W'(DEPTH)) begin
                if (out_room) begin
                  cmd_take        = 1'b1;
                  out_load        = 1'b1;
                  res_next.status = ST_FULL;
                end
              end else begin
                cmd_take  = 1'b1;
                mem_we    = 1'b1;
                fill_next = fill + 1'b1;
              end
            end
            K_COUNT: begin
              if (out_room) begin
                cmd_take         = 1'b1;
                out_load         = 1'b1;
                res_next.content = C_COUNT;
                res_next.entries = ENTRY_W'(fill);
              end
            end
            default: begin
              if (fill == '0) begin
                if (out_room) begin
                  cmd_take         = 1'b1;
                  out_load         = 1'b1;
                  res_next.status  = ST_EMPTY;
                  res_next.content = (cmd.kind == K_POP) ? cmd.choice : C_RECORD;
                end
              end else begin
                cmd_take    = 1'b1;
                rd_en       = 1'b1;
                rd_addr     = PTR_W'(fill - 1'b1);
                ptr_next    = PTR_W'(fill - 1'b1);
                kind_next   = cmd.kind;
                choice_next = cmd.choice;
                state_next  = S_READ;
                if (cmd.kind == K_POP) fill_next = fill - 1'b1;
                else if (cmd.kind == K_ALL) fill_next = '0;
              end
            end
          endcase
        end
      end
      S_READ: begin
        if (out_room) begin
          out_load = 1'b1;
          if (cur_kind == K_POP) begin
            res_next.content = cur_choice;
            case (cur_choice)
              C_NAME: begin
                res_next.rec.name_first  = rd_data.name_first;
                res_next.rec.name_second = rd_data.name_second;
              end
              C_AGE: res_next.rec.age = rd_data.age;
              default: begin
                res_next.rec.year  = rd_data.year;
                res_next.rec.month = rd_data.month;
                res_next.rec.day   = rd_data.day;
              end
            endcase
            state_next = S_IDLE;
          end else begin
            res_next.content = C_RECORD;
            res_next.rec     = rd_data;
            res_next.last    = (ptr == '0);
            if (ptr == '0) begin
              state_next = S_IDLE;
            end else begin
              ptr_next = ptr - 1'b1;
              rd_en    = 1'b1;
              rd_addr  = ptr - 1'b1;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("fill level above depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (fill < FILL_W'(DEPTH)))
    else $error("record write into a full stack");

  a_read_kind: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (cur_kind == K_POP || cur_kind == K_ALL || cur_kind == K_LIST))
    else $error("read sequence for a command that reads nothing");

  a_pop_drops_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_take && cmd.kind == K_POP && fill != '0)
      |=> (fill == $past(fill) - 1'b1))
    else $error("pop did not drop one record");

  a_take_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (cmd_valid && state == S_IDLE))
    else $error("command taken while none waits or busy");

endmodule
